FILE: sv/bcz_pkg.sv
// Shared definitions for the cubic Bezier point evaluator.
// Register map and reset values; no dependencies.
`default_nettype none

package bcz_pkg;

  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_e;

  // Reset values, truncated to the coordinate width where they are used
  localparam int RESET_COORD [NUM_REGS] = '{
    -8192, -8192, -8192, 8192, 8192, 8192, 8192, -8192
  };

endpackage

`default_nettype wire

FILE: sv/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator, top level: de Casteljau pipeline.
// Depends on bcz_pkg, bcz_cfg_regs and bcz_lerp.
//
// Usage: load the four control points through cfg_we_i / cfg_idx_i /
// cfg_wdata_i (index 0..7 = p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y)
// while the pipeline is empty, then send one beat of param_t_i per cycle on
// the in_valid_i / in_ready_o channel. Each beat yields one beat of
// curve_x_o / curve_y_o on out_valid_o / out_ready_i.
// A t above 1.0 is clamped to 1.0.
// Pipeline: four register stages (the input register, loaded at the accepting
// edge, then one register per interpolation level: 3, 2, 1 points per axis);
// out_valid_o rises once a beat has passed through all four.
// Throughput: one beat per cycle while out_ready_i stays high; each level
// holds one multiplier and add per point between registers.
// Reset loads the default control points and empties the pipeline.
// When the receiver stalls, each stage holds its beat and empty stages
// still fill, so in_ready_o falls only once all four stages are full.
`default_nettype none

module cubic_bezier_point_eval #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bcz_pkg::REG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [PARAM_FRAC_BITS:0]          param_t_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [COORD_BITS-1:0]           curve_x_o,
  output logic signed [COORD_BITS-1:0]           curve_y_o
);

  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS;

  logic signed [COORD_BITS-1:0] pts_x [4];
  logic signed [COORD_BITS-1:0] pts_y [4];

  bcz_cfg_regs #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pts_x_o     (pts_x),
    .pts_y_o     (pts_y)
  );

  // stage valids and ready chain
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = !v0_q || rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) v0_q <= in_valid_i;
      if (rdy1)       v1_q <= v0_q;
      if (rdy2)       v2_q <= v1_q;
      if (rdy3)       v3_q <= v2_q;
    end
  end

  // stage 0: clamp t
  logic [TW-1:0] t0_d, t0_q;

  assign t0_d = (param_t_i > T_ONE) ? T_ONE : param_t_i;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) t0_q <= t0_d;
  end

  // level 1: three points per axis
  logic signed [COORD_BITS-1:0] l1x_d [3], l1y_d [3];
  logic signed [COORD_BITS-1:0] l1x_q [3], l1y_q [3];
  logic [TW-1:0]                t1_q;

  for (genvar i = 0; i < 3; i++) begin : g_lvl1
    bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_x (
      .a_i (pts_x[i]), .b_i (pts_x[i+1]), .t_i (t0_q), .y_o (l1x_d[i])
    );
    bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_y (
      .a_i (pts_y[i]), .b_i (pts_y[i+1]), .t_i (t0_q), .y_o (l1y_d[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      l1x_q <= l1x_d;
      l1y_q <= l1y_d;
      t1_q  <= t0_q;
    end
  end

  // level 2: two points per axis
  logic signed [COORD_BITS-1:0] l2x_d [2], l2y_d [2];
  logic signed [COORD_BITS-1:0] l2x_q [2], l2y_q [2];
  logic [TW-1:0]                t2_q;

  for (genvar i = 0; i < 2; i++) begin : g_lvl2
    bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_x (
      .a_i (l1x_q[i]), .b_i (l1x_q[i+1]), .t_i (t1_q), .y_o (l2x_d[i])
    );
    bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_y (
      .a_i (l1y_q[i]), .b_i (l1y_q[i+1]), .t_i (t1_q), .y_o (l2y_d[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      l2x_q <= l2x_d;
      l2y_q <= l2y_d;
      t2_q  <= t1_q;
    end
  end

  // level 3: final point, output register
  logic signed [COORD_BITS-1:0] x3_d, y3_d, x3_q, y3_q;

  bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_lvl3_x (
    .a_i (l2x_q[0]), .b_i (l2x_q[1]), .t_i (t2_q), .y_o (x3_d)
  );
  bcz_lerp #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_lvl3_y (
    .a_i (l2y_q[0]), .b_i (l2y_q[1]), .t_i (t2_q), .y_o (y3_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      x3_q <= x3_d;
      y3_q <= y3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign curve_x_o   = x3_q;
  assign curve_y_o   = y3_q;

  // a beat taken at the input always lands in the first stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v0_q)
    else $error("accepted beat did not reach stage 0");

  // clamped t never exceeds one
  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> (t0_q <= T_ONE))
    else $error("stage 0 parameter above one");

  // a blocked middle stage keeps its beat
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> v2_q)
    else $error("stalled beat dropped in level 2");

  // back-pressure only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input blocked with a bubble in the pipeline");

endmodule

`default_nettype wire

FILE: sv/bcz_cfg_regs.sv
// Control point register file, written through the plain config port.
// Depends on bcz_pkg for the register map and reset values.
`default_nettype none

module bcz_cfg_regs #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bcz_pkg::REG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]                cfg_wdata_i,
  output logic signed [COORD_BITS-1:0]              pts_x_o [4],
  output logic signed [COORD_BITS-1:0]              pts_y_o [4]
);

  logic signed [COORD_BITS-1:0] regs_q [bcz_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bcz_pkg::NUM_REGS; i++) begin
        regs_q[i] <= COORD_BITS'(bcz_pkg::RESET_COORD[i]);
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign pts_x_o[0] = regs_q[bcz_pkg::REG_P0_X];
  assign pts_x_o[1] = regs_q[bcz_pkg::REG_P1_X];
  assign pts_x_o[2] = regs_q[bcz_pkg::REG_P2_X];
  assign pts_x_o[3] = regs_q[bcz_pkg::REG_P3_X];
  assign pts_y_o[0] = regs_q[bcz_pkg::REG_P0_Y];
  assign pts_y_o[1] = regs_q[bcz_pkg::REG_P1_Y];
  assign pts_y_o[2] = regs_q[bcz_pkg::REG_P2_Y];
  assign pts_y_o[3] = regs_q[bcz_pkg::REG_P3_Y];

endmodule

`default_nettype wire

FILE: sv/bcz_lerp.sv
// One linear interpolation a + floor((b - a) * t / 2^frac), combinational.
// No package dependencies; instanced per point in each pipeline level.
`default_nettype none

module bcz_lerp #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic signed [COORD_BITS-1:0]      a_i,
  input  wire logic signed [COORD_BITS-1:0]      b_i,
  input  wire logic        [PARAM_FRAC_BITS:0]   t_i,
  output logic signed      [COORD_BITS-1:0]      y_o
);

  localparam int TW = PARAM_FRAC_BITS + 1;

  logic signed [COORD_BITS:0]      diff;
  logic signed [COORD_BITS+TW:0]   prod;
  logic signed [COORD_BITS+TW:0]   scaled;

  assign diff   = {b_i[COORD_BITS-1], b_i} - {a_i[COORD_BITS-1], a_i};
  assign prod   = diff * $signed({1'b0, t_i});
  // arithmetic shift gives floor for negative products too
  assign scaled = prod >>> PARAM_FRAC_BITS;
  // t stays within [0, 1], so the sum never leaves the coordinate range
  assign y_o    = a_i + scaled[COORD_BITS-1:0];

endmodule

`default_nettype wire

FILE: dv/bcz_point_checker.sv
// Checker for the cubic Bezier point evaluator: tracks control-point writes,
// predicts each curve point and compares it with what leaves the block.
// Depends on bcz_pkg for the register map and the reset control points.
`default_nettype none

module bcz_point_checker #(
  parameter int COORD_BITS      = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bcz_pkg::REG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]             cfg_wdata_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire logic [PARAM_FRAC_BITS:0]          param_t_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic signed [COORD_BITS-1:0]      curve_x_i,
  input  wire logic signed [COORD_BITS-1:0]      curve_y_i,
  output int                                     fail_count_o,
  output int                                     in_flight_o
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam longint T_ONE = longint'(1) << PARAM_FRAC_BITS;

  coord_t ctrl_pts [bcz_pkg::NUM_REGS];
  point_t expected_pts [$];

  // a + floor((b - a) * t / 2^frac); >>> on a signed longint floors
  function automatic longint interp_floor(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> PARAM_FRAC_BITS);
  endfunction

  function automatic coord_t casteljau_axis(longint c0, longint c1, longint c2,
                                            longint c3, longint t);
    longint l0, l1, l2, m0, m1;
    l0 = interp_floor(c0, c1, t);
    l1 = interp_floor(c1, c2, t);
    l2 = interp_floor(c2, c3, t);
    m0 = interp_floor(l0, l1, t);
    m1 = interp_floor(l1, l2, t);
    return coord_t'(interp_floor(m0, m1, t));
  endfunction

  function automatic point_t curve_point(logic [PARAM_FRAC_BITS:0] t_raw);
    longint t;
    point_t p;
    // t above 1.0 is clamped
    t = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
    p.x = casteljau_axis(ctrl_pts[bcz_pkg::REG_P0_X], ctrl_pts[bcz_pkg::REG_P1_X],
                         ctrl_pts[bcz_pkg::REG_P2_X], ctrl_pts[bcz_pkg::REG_P3_X], t);
    p.y = casteljau_axis(ctrl_pts[bcz_pkg::REG_P0_Y], ctrl_pts[bcz_pkg::REG_P1_Y],
                         ctrl_pts[bcz_pkg::REG_P2_Y], ctrl_pts[bcz_pkg::REG_P3_Y], t);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t want;
    int errs;
    if (!rst_ni) begin
      for (int i = 0; i < bcz_pkg::NUM_REGS; i++) begin
        ctrl_pts[i] = coord_t'(bcz_pkg::RESET_COORD[i]);
      end
      expected_pts.delete();
      fail_count_o <= 0;
      in_flight_o  <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) ctrl_pts[cfg_idx_i] = coord_t'(cfg_wdata_i);
      if (in_valid_i && in_ready_i) expected_pts.push_back(curve_point(param_t_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected result beat x=%0d y=%0d", $time,
                   curve_x_i, curve_y_i);
          errs++;
        end else begin
          want = expected_pts.pop_front();
          if (curve_x_i !== want.x) begin
            $display("%0t: curve_x mismatch, expected %0d, got %0d", $time,
                     want.x, curve_x_i);
            errs++;
          end
          if (curve_y_i !== want.y) begin
            $display("%0t: curve_y mismatch, expected %0d, got %0d", $time,
                     want.y, curve_y_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      in_flight_o  <= expected_pts.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/cubic_bezier_point_eval_test.sv
// Top of the cubic Bezier point evaluator regression: drives control points
// and curve parameters, applies back-pressure and gives the verdict.
// Depends on bcz_pkg, cubic_bezier_point_eval and bcz_point_checker.
`default_nettype none

module cubic_bezier_point_eval_test;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PHASE_BEATS     = 175;
  localparam int NUM_PHASES      = 8;

  localparam logic [COORD_BITS-1:0] COORD_MIN = 16'sh8000;
  localparam logic [COORD_BITS-1:0] COORD_MAX = 16'sh7fff;
  localparam logic [PARAM_FRAC_BITS:0] T_ONE  = 17'h10000;
  localparam logic [PARAM_FRAC_BITS:0] T_TOP  = 17'h1ffff;

  logic                               clk_i;
  logic                               rst_ni       = 1'b0;
  logic                               cfg_we_i     = 1'b0;
  logic [bcz_pkg::REG_IDX_BITS-1:0]   cfg_idx_i    = '0;
  logic [COORD_BITS-1:0]              cfg_wdata_i  = '0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_ready_o;
  logic [PARAM_FRAC_BITS:0]           param_t_i    = '0;
  logic                               out_valid_o;
  logic                               out_ready_i  = 1'b0;
  logic signed [COORD_BITS-1:0]       curve_x_o;
  logic signed [COORD_BITS-1:0]       curve_y_o;

  int fail_count;
  int in_flight;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  logic [COORD_BITS-1:0] next_pts [bcz_pkg::NUM_REGS];

  cubic_bezier_point_eval #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .param_t_i   (param_t_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .curve_x_o   (curve_x_o),
    .curve_y_o   (curve_y_o)
  );

  bcz_point_checker #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_point_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .param_t_i    (param_t_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .curve_x_i    (curve_x_o),
    .curve_y_i    (curve_y_o),
    .fail_count_o (fail_count),
    .in_flight_o  (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // one beat of t; valid stays high afterwards unless the next beat idles first
  task automatic send_param(input logic [PARAM_FRAC_BITS:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    param_t_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  task automatic load_points;
    for (int i = 0; i < bcz_pkg::NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= bcz_pkg::reg_idx_e'(i);
      cfg_wdata_i <= next_pts[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(input bit extremes);
    if (!extremes) return COORD_BITS'($urandom);
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PARAM_FRAC_BITS:0] pick_param;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return 17'd1;
          2:       return T_ONE - 17'd1;
          default: return T_ONE;
        endcase
      end
      1:       return 17'($urandom_range(T_ONE + 1, T_TOP));
      default: return 17'($urandom_range(0, T_ONE));
    endcase
  endfunction

  initial begin : stimulus
    logic [PARAM_FRAC_BITS:0] reset_ts [] = '{17'd0, T_ONE, 17'd32768, 17'd1,
                                              T_ONE - 17'd1, T_ONE + 17'd1, T_TOP};
    logic [PARAM_FRAC_BITS:0] swing_ts [] = '{17'd0, 17'd1, 17'd2, 17'd32768,
                                              T_ONE - 17'd1, T_ONE, 17'd98304,
                                              T_TOP, 17'd21845};
    logic [PARAM_FRAC_BITS:0] flat_ts  [] = '{17'd1, T_ONE - 17'd1, 17'd43690};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset control points
    foreach (reset_ts[i]) send_param(reset_ts[i]);
    drain();

    // full-scale swings between neighbours: largest differences, negative floors
    next_pts = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
    load_points();
    foreach (swing_ts[i]) send_param(swing_ts[i]);
    drain();

    // every point at the top of the range
    foreach (next_pts[i]) next_pts[i] = COORD_MAX;
    load_points();
    foreach (flat_ts[i]) send_param(flat_ts[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      foreach (next_pts[i]) next_pts[i] = pick_coord(ph % 2 == 1);
      load_points();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // hold off mid-phase until the pipeline has emptied
        if (ph == 2 && n == PHASE_BEATS / 2) drain();
        send_param(pick_param());
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cubic_bezier_point_eval regression: pass");
    end else begin
      $display("cubic_bezier_point_eval regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("cubic_bezier_point_eval regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/bcz_pkg.sv
sv/bcz_cfg_regs.sv
sv/bcz_lerp.sv
sv/cubic_bezier_point_eval.sv
dv/bcz_point_checker.sv
dv/cubic_bezier_point_eval_test.sv
